// File: src/assert_macros.svh
// Assertion macros for the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while rst is high.
`define CN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("port check failed");

// Clocked assertion that is also checked during reset.
`define CN_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("port check failed");

`endif

// File: src/cncr_pkg.sv
// Types and constants of the CAN node control responder.
package cncr_pkg;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int ERR_W       = 16;

   // event kinds on req_tuser
   localparam logic [1:0] MODE_CTRL   = 2'd0;
   localparam logic [1:0] MODE_POLL   = 2'd1;
   localparam logic [1:0] MODE_REPORT = 2'd2;

   // result actions on rsp_tuser
   localparam logic [2:0] ACT_RESET = 3'd1;
   localparam logic [2:0] ACT_STORE = 3'd2;
   localparam logic [2:0] ACT_BEAT  = 3'd3;
   localparam logic [2:0] ACT_ERROR = 3'd4;

   // heartbeat modes
   localparam logic [1:0] BEAT_OFF      = 2'd0;
   localparam logic [1:0] BEAT_ONCE     = 2'd1;
   localparam logic [1:0] BEAT_PERIODIC = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_CLASS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_ID    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_CMD  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAT_CMD   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDCHG_CMD  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERR_ID     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAT_TYPE  = 3'd7;

   // first member lands in the top bits, so frame_ident sits at bit 0
   typedef struct packed {
      logic             error_slot_free;
      logic             heartbeat_slot_free;
      logic [ERR_W-1:0] reported_code;
      logic [31:0]      now;
      logic [7:0]       data_second;
      logic [7:0]       data_first;
      logic [3:0]       frame_bytes;
      logic [10:0]      frame_ident;
   } req_type;

   localparam int REQ_FIELD_W = $bits(req_type);

   typedef struct packed {
      logic             last;
      logic [2:0]       action;
      logic [2:0]       current_node;
      logic [ERR_W-1:0] error_word;
      logic [3:0]       tx_bytes;
      logic [10:0]      tx_ident;
   } rsp_type;

   localparam int RSP_FIELD_W = 34;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [ERR_W-1:0] push_data;
   } errq_ctl_type;

   typedef struct packed {
      logic             empty;
      logic             full;
      logic [ERR_W-1:0] head_data;
   } errq_stat_type;

endpackage

// File: src/can_node_control_responder.sv
// Top level of the CAN node control responder.
// Events enter on the req_ stream: req_tuser gives the kind (control frame,
// poll, error report), req_tdata the frame fields, time, reported code and slot flags.
// Results leave on the rsp_ stream: rsp_tuser is the action, rsp_tdata the
// frame to send and the node number in force, rsp_tlast marks the final
// result of an event. Control frames give at most one result, polls up to
// two (queued error first, then a due heartbeat); reports give none.
// An event passes an input register, then the decode and state update,
// then a two-entry result register, which it enters when the input register
// advances. One event is taken per cycle while each gives at most one result
// and rsp_tready is high; an event with two results holds the next event in
// the input register, since the result register must be down to its last
// result, and that one taken, before the next event is decoded.
// When rsp_tready is low, results wait in the result register and req_tready
// drops once the input register is also occupied.
// Reset empties both registers and the error FIFO, disarms the heartbeat,
// sets node number 1 and loads the register defaults. The user must write registers
// through csr_ only while no event is in flight; the block itself does not enforce this.
module can_node_control_responder import cncr_pkg::*; #(
   parameter int ERROR_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // frame_ident, frame_bytes, data_first, data_second, now, reported_code,
   // heartbeat_slot_free, error_slot_free
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tx_ident, tx_bytes, error_word, current_node
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // action
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   logic [5:0]  node_class_ff;
   logic [2:0]  version_length_ff;
   logic [2:0]  reset_command_ff;
   logic [2:0]  heartbeat_command_ff;
   logic [2:0]  id_change_command_ff;
   logic [10:0] error_frame_id_ff;
   logic [1:0]  heartbeat_type_ff;

   // node state
   logic [2:0]  node_ff;
   logic [1:0]  beat_mode_ff;
   logic [15:0] beat_period_ff;
   logic [31:0] beat_last_ff;

   // input register
   logic        stg_valid_ff;
   req_type     stg_ff;
   logic [1:0]  stg_mode_ff;

   // result register
   logic [1:0]  ob_cnt_ff;
   rsp_type     ob0_ff;
   rsp_type     ob1_ff;

   errq_ctl_type  errq_ctl;
   errq_stat_type errq_stat;

   logic        room;
   logic        advance;
   logic        rsp_pop;
   logic [5:0]  frame_class;
   logic [2:0]  frame_cmd;
   logic        ctrl_ok;
   logic        is_rst;
   logic        data_zero;
   logic        rst_hit;
   logic        beat_cmd;
   logic        beat_once_hit;
   logic        beat_per_hit;
   logic        idc_hit;
   logic        err_send;
   logic        beat_send;
   logic [31:0] elapsed;
   logic [3:0]  beat_len;
   rsp_type     err_res;
   rsp_type     beat_res;
   rsp_type     cmd_res;
   rsp_type     r0;
   rsp_type     r1;
   logic [1:0]  n_res;

   assign room       = (ob_cnt_ff == 2'd0) || ((ob_cnt_ff == 2'd1) && rsp_tready);
   assign advance    = stg_valid_ff && room;
   assign req_tready = !stg_valid_ff || advance;
   assign rsp_tvalid = (ob_cnt_ff != 2'd0);
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stg_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stg_ff      <= req_type'(req_tdata[REQ_FIELD_W-1:0]);
         stg_mode_ff <= req_tuser;
      end
   end

   // frame decode
   always_comb begin
      frame_class = stg_ff.frame_ident[8:3];
      frame_cmd   = stg_ff.frame_ident[2:0];
      data_zero   = (stg_ff.data_first == 8'd0) && (stg_ff.data_second == 8'd0);
      ctrl_ok     = (stg_mode_ff == MODE_CTRL) && (stg_ff.frame_ident[10:9] == 2'b00)
                    && ((frame_class == 6'd0) || (frame_class == node_class_ff));
      is_rst      = (frame_cmd == reset_command_ff) && (stg_ff.frame_bytes == 4'd1);
      rst_hit     = ctrl_ok && is_rst
                    && ((stg_ff.data_first == 8'd0)
                        || (stg_ff.data_first == {5'd0, node_ff}));
      beat_cmd    = ctrl_ok && !is_rst && (frame_cmd == heartbeat_command_ff);
      beat_once_hit = beat_cmd && ((stg_ff.frame_bytes == 4'd0)
                                   || ((stg_ff.frame_bytes == 4'd2) && data_zero));
      beat_per_hit  = beat_cmd && (stg_ff.frame_bytes == 4'd2) && !data_zero;
      // a matching heartbeat code shadows the id change code
      idc_hit     = ctrl_ok && !is_rst && (frame_cmd != heartbeat_command_ff)
                    && (frame_cmd == id_change_command_ff)
                    && (stg_ff.frame_bytes == 4'd2)
                    && (stg_ff.data_first == {5'd0, node_ff})
                    && (stg_ff.data_second[7:3] == 5'd0)
                    && (stg_ff.data_second[2:0] != 3'd0);
   end

   // poll decode
   always_comb begin
      elapsed   = stg_ff.now - beat_last_ff;
      err_send  = (stg_mode_ff == MODE_POLL) && !errq_stat.empty
                  && stg_ff.error_slot_free;
      beat_send = (stg_mode_ff == MODE_POLL) && (beat_mode_ff != BEAT_OFF)
                  && stg_ff.heartbeat_slot_free && (elapsed >= {16'd0, beat_period_ff});
      if (version_length_ff < 3'd2) begin
         beat_len = 4'd2;
      end else if (version_length_ff > 3'd4) begin
         beat_len = 4'd4;
      end else begin
         beat_len = {1'b0, version_length_ff};
      end
   end

   always_comb begin
      err_res              = '0;
      err_res.action       = ACT_ERROR;
      err_res.tx_ident     = error_frame_id_ff;
      err_res.tx_bytes     = 4'd4;
      err_res.error_word   = errq_stat.head_data;
      err_res.current_node = node_ff;

      beat_res              = '0;
      beat_res.action       = ACT_BEAT;
      beat_res.tx_ident     = {heartbeat_type_ff, node_class_ff, node_ff};
      beat_res.tx_bytes     = (beat_mode_ff == BEAT_ONCE) ? beat_len : 4'd0;
      beat_res.current_node = node_ff;

      cmd_res              = '0;
      cmd_res.action       = rst_hit ? ACT_RESET : ACT_STORE;
      cmd_res.current_node = rst_hit ? node_ff : stg_ff.data_second[2:0];

      r0    = '0;
      r1    = beat_res;
      n_res = 2'd0;
      if (rst_hit || idc_hit) begin
         r0    = cmd_res;
         n_res = 2'd1;
      end else if (err_send) begin
         r0    = err_res;
         n_res = beat_send ? 2'd2 : 2'd1;
      end else if (beat_send) begin
         r0    = beat_res;
         n_res = 2'd1;
      end
      r0.last = (n_res == 2'd1);
      r1.last = 1'b1;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else if (advance) begin
         ob_cnt_ff <= n_res;
      end else if (rsp_pop) begin
         ob_cnt_ff <= ob_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ob0_ff <= r0;
         ob1_ff <= r1;
      end else if (rsp_pop) begin
         ob0_ff <= ob1_ff;
      end
   end

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, ob0_ff.current_node,
                       ob0_ff.error_word, ob0_ff.tx_bytes, ob0_ff.tx_ident};
   assign rsp_tuser = ob0_ff.action;
   assign rsp_tlast = ob0_ff.last;

   // error FIFO
   always_comb begin
      errq_ctl.push      = advance && (stg_mode_ff == MODE_REPORT) && !errq_stat.full;
      errq_ctl.pop       = advance && err_send;
      errq_ctl.push_data = stg_ff.reported_code;
   end

   cncr_errq #(
      .ERROR_DEPTH(ERROR_DEPTH)
   ) u_errq (
      .clock(clock),
      .reset(reset),
      .ctl  (errq_ctl),
      .stat (errq_stat)
   );

   // heartbeat state
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_mode_ff   <= BEAT_OFF;
         beat_period_ff <= 16'd0;
         beat_last_ff   <= 32'd0;
      end else if (advance) begin
         if (beat_once_hit) begin
            beat_mode_ff   <= BEAT_ONCE;
            beat_period_ff <= 16'd0;
            beat_last_ff   <= stg_ff.now;
         end else if (beat_per_hit) begin
            beat_mode_ff   <= BEAT_PERIODIC;
            beat_period_ff <= {stg_ff.data_second, stg_ff.data_first};
            beat_last_ff   <= stg_ff.now;
         end else if (beat_send) begin
            if (beat_mode_ff == BEAT_ONCE) begin
               beat_mode_ff <= BEAT_OFF;
            end else begin
               beat_last_ff <= stg_ff.now;
            end
         end
      end
   end

   // node number and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff              <= 3'd1;
         node_class_ff        <= 6'd0;
         version_length_ff    <= 3'd2;
         reset_command_ff     <= 3'd0;
         heartbeat_command_ff <= 3'd1;
         id_change_command_ff <= 3'd2;
         error_frame_id_ff    <= 11'd0;
         heartbeat_type_ff    <= 2'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_CLASS: node_class_ff <= csr_wdata[5:0];
            CSR_BOOT_ID:    node_ff <= (csr_wdata[2:0] == 3'd0) ? 3'd1 : csr_wdata[2:0];
            CSR_VERSION:    version_length_ff <= csr_wdata[2:0];
            CSR_RESET_CMD:  reset_command_ff <= csr_wdata[2:0];
            CSR_BEAT_CMD:   heartbeat_command_ff <= csr_wdata[2:0];
            CSR_IDCHG_CMD:  id_change_command_ff <= csr_wdata[2:0];
            CSR_ERR_ID:     error_frame_id_ff <= csr_wdata;
            CSR_BEAT_TYPE:  heartbeat_type_ff <= csr_wdata[1:0];
            default:        node_class_ff <= node_class_ff;
         endcase
      end else if (advance && idc_hit) begin
         node_ff <= stg_ff.data_second[2:0];
      end
   end

endmodule

// File: src/cncr_errq.sv
// Error code FIFO with a registered head read.
module cncr_errq import cncr_pkg::*; #(
   parameter int ERROR_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  errq_ctl_type  ctl,
   output errq_stat_type stat
);

   localparam int PTR_W = $clog2(ERROR_DEPTH);
   localparam int CNT_W = $clog2(ERROR_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ERROR_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ERROR_DEPTH);

   logic [ERR_W-1:0] mem [ERROR_DEPTH];

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ERR_W-1:0] head_data_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      if (ctl.push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      case ({ctl.push, ctl.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // head word is prefetched; a push into the slot about to be the head is forwarded
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= ctl.push_data;
      end
      if (ctl.push && (tail_ff == head_in)) begin
         head_data_ff <= ctl.push_data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == FULL_CNT);
   assign stat.head_data = head_data_ff;

endmodule

// File: src/cncr_port_checker.sv
// Port checker for the CAN node control responder and its bind.
`include "assert_macros.svh"

module cncr_port_checker import cncr_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [2:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   // nothing is offered right after reset
   `CN_ASSERT_ALWAYS(a_idle_after_reset, clock, !reset && $past(reset) |-> !rsp_tvalid)

   // a stalled result holds
   `CN_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))

   // reset and id change results carry no frame and end their event
   `CN_ASSERT(a_cmd_plain, clock, reset,
      rsp_tvalid && ((rsp_tuser == ACT_RESET) || (rsp_tuser == ACT_STORE))
      |-> (rsp_tdata[30:0] == 31'd0) && rsp_tlast)

   // only an error frame may be followed by a second result, and that is a heartbeat
   `CN_ASSERT(a_pair_order, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast
      |-> (rsp_tuser == ACT_ERROR) ##1 (rsp_tvalid && (rsp_tuser == ACT_BEAT)))

endmodule

bind can_node_control_responder cncr_port_checker u_port_checker (.*);
